### hw/rtl/apcc_pkg.sv
// Shared types, constants and helpers of the analog prototype coefficient calculator.
`timescale 1ns / 1ps
`default_nettype none

package apcc_pkg;

	// output format
	localparam int OUT_FRAC_BITS = 24;
	localparam logic [63:0] OUT_MAX = 64'((64'd1 << 47) - 64'd1);

	// fixed-point constants
	localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic signed [29:0] DB_LOG2 = 30'sd356689313;
	localparam logic [31:0] SCALE_RESET = 32'd1686629713;

	// pipeline depths and sizes
	localparam int POW_TERMS = 12;
	localparam int POW_LAT = 3 * POW_TERMS + 2;
	localparam int QMUL_LAT = 2;
	localparam int QUO_W = 64;
	localparam int DIV_STEP = 4;
	localparam int DIV_LAT = QUO_W / DIV_STEP;
	localparam int LAT = 1 + POW_LAT + QMUL_LAT + DIV_LAT + QMUL_LAT;
	localparam int NQM = 9;

	// filter kinds
	localparam logic [3:0] CMD_LP1 = 4'd0;
	localparam logic [3:0] CMD_HP1 = 4'd1;
	localparam logic [3:0] CMD_TILT1 = 4'd2;
	localparam logic [3:0] CMD_LS1 = 4'd3;
	localparam logic [3:0] CMD_HS1 = 4'd4;
	localparam logic [3:0] CMD_LP2 = 4'd5;
	localparam logic [3:0] CMD_HP2 = 4'd6;
	localparam logic [3:0] CMD_BP2 = 4'd7;
	localparam logic [3:0] CMD_NOTCH2 = 4'd8;
	localparam logic [3:0] CMD_PEAK2 = 4'd9;
	localparam logic [3:0] CMD_TILT2 = 4'd10;
	localparam logic [3:0] CMD_LS2 = 4'd11;
	localparam logic [3:0] CMD_HS2 = 4'd12;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_QZERO = 2'd2;

	typedef struct packed {
		logic [3:0] cmd;
		logic [23:0] qual;
		logic [39:0] w;
	} ctx_t;

	typedef struct packed {
		ctx_t ctx;
		logic [47:0] w2;
		logic [37:0] a;
		logic [37:0] ai;
	} m1_t;

	typedef struct packed {
		logic [47:0] val;
		logic sat;
	} out_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic kill;
		logic qz;
		out_t o0e;
		out_t o1;
		out_t o2;
		out_t o4;
		logic [37:0] a;
		logic [37:0] ai;
	} mid_t;

	typedef struct packed {
		mid_t mid;
		logic [63:0] q1;
		logic [63:0] q2;
	} fin_t;

	typedef struct packed {
		logic [47:0] a;
		logic [47:0] b;
		logic [47:0] c;
		logic [47:0] d;
		logic [47:0] e;
		logic [1:0] status;
	} res_t;

	// Q32.32 to output format, truncating and clamping
	function automatic out_t to_out(input logic [63:0] v);
		logic [63:0] sh;
		out_t r;
		sh = v >> (32 - OUT_FRAC_BITS);
		if (sh > OUT_MAX) begin
			r.val = OUT_MAX[47:0];
			r.sat = 1'b1;
		end else begin
			r.val = sh[47:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/apcc_pow2.sv
// Pipelined 2^x: fraction through a Horner series for e^y, then a shift by the integer part.
`timescale 1ns / 1ps
`default_nettype none

module apcc_pow2 (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [54:0] x,
	output logic [37:0] y
);

	localparam int NT = apcc_pkg::POW_TERMS;

	logic [30:0] y_s0;
	logic [3:0] r_s0;
	logic [5:0] rr;
	logic [63:0] yp;

	logic [31:0] acc_in [NT];
	logic [30:0] y_in [NT];
	logic [3:0] r_in [NT];

	logic [31:0] hv_s1 [NT];
	logic [30:0] hy_s1 [NT];
	logic [3:0] hr_s1 [NT];
	logic [31:0] hv_s2 [NT];
	logic [31:0] hq_s2 [NT];
	logic [30:0] hy_s2 [NT];
	logic [3:0] hr_s2 [NT];
	logic [31:0] acc_s3 [NT];
	logic [30:0] hy_s3 [NT];
	logic [3:0] hr_s3 [NT];

	logic [37:0] res_s4;

	// front: y = frac * ln2, shift = 5 - floor(x)
	assign yp = 64'(x[48:17]) * 64'(apcc_pkg::LN2_Q32);
	assign rr = 6'd5 - x[54:49];

	always_ff @(posedge clk) begin
		if (en) begin
			y_s0 <= yp[63:33];
			r_s0 <= rr[3:0];
		end
	end

	// Horner steps, divisor running from the top term down to one
	for (genvar i = 0; i < NT; i++) begin : g_term
		localparam int K = NT - i;
		localparam logic [36:0] RCP = 37'((64'd1 << 36) / K);

		logic [63:0] pm;
		logic [68:0] mm;
		logic [31:0] rem;
		logic [31:0] qc;

		if (i == 0) begin : g_first
			assign acc_in[i] = apcc_pkg::ONE_Q31;
			assign y_in[i] = y_s0;
			assign r_in[i] = r_s0;
		end else begin : g_next
			assign acc_in[i] = acc_s3[i-1];
			assign y_in[i] = hy_s3[i-1];
			assign r_in[i] = hr_s3[i-1];
		end

		assign pm = 64'(acc_in[i]) * 64'(y_in[i]);
		assign mm = 69'(hv_s1[i]) * 69'(RCP);
		// reciprocal estimate is low by at most one
		assign rem = hv_s2[i] - hq_s2[i] * 32'(K);
		assign qc = (rem >= 32'(K)) ? hq_s2[i] + 32'd1 : hq_s2[i];

		always_ff @(posedge clk) begin
			if (en) begin
				hv_s1[i] <= pm[62:31];
				hy_s1[i] <= y_in[i];
				hr_s1[i] <= r_in[i];
				hv_s2[i] <= hv_s1[i];
				hq_s2[i] <= mm[67:36];
				hy_s2[i] <= hy_s1[i];
				hr_s2[i] <= hr_s1[i];
				acc_s3[i] <= apcc_pkg::ONE_Q31 + qc;
				hy_s3[i] <= hy_s2[i];
				hr_s3[i] <= hr_s2[i];
			end
		end
	end

	// scale by 2^(n+1)
	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= {acc_s3[NT-1], 6'b0} >> hr_s3[NT-1];
		end
	end

	assign y = res_s4;

endmodule

`default_nettype wire

### hw/rtl/apcc_div.sv
// Pipelined restoring divider: floor(num * 2^16 / den), four quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none

module apcc_div (
	input wire logic clk,
	input wire logic en,
	input wire logic [47:0] num,
	input wire logic [23:0] den,
	output logic [63:0] quo
);

	localparam int NS = apcc_pkg::DIV_LAT;

	logic [63:0] x_in [NS];
	logic [23:0] r_in [NS];
	logic [23:0] d_in [NS];
	logic [63:0] x_nx [NS];
	logic [23:0] r_nx [NS];

	logic [63:0] x_s [NS];
	logic [23:0] r_s [NS];
	logic [23:0] d_s [NS];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		if (j == 0) begin : g_first
			assign x_in[j] = {num, 16'b0};
			assign r_in[j] = '0;
			assign d_in[j] = den;
		end else begin : g_next
			assign x_in[j] = x_s[j-1];
			assign r_in[j] = r_s[j-1];
			assign d_in[j] = d_s[j-1];
		end

		// dividend bits shift out the top while quotient bits shift in below
		always_comb begin
			logic [24:0] t;
			logic [63:0] xv;
			logic [23:0] rv;
			xv = x_in[j];
			rv = r_in[j];
			for (int b = 0; b < apcc_pkg::DIV_STEP; b++) begin
				t = {rv, xv[63]};
				xv = {xv[62:0], 1'b0};
				if (t >= {1'b0, d_in[j]}) begin
					t = t - {1'b0, d_in[j]};
					xv[0] = 1'b1;
				end
				rv = t[23:0];
			end
			x_nx[j] = xv;
			r_nx[j] = rv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[j] <= x_nx[j];
				r_s[j] <= r_nx[j];
				d_s[j] <= d_in[j];
			end
		end
	end

	assign quo = x_s[NS-1];

endmodule

`default_nettype wire

### hw/rtl/analog_prototype_coeff_calc_unit.sv
// Top level of the analog prototype coefficient calculator.
// Throughput: one beat per cycle; the pipeline halts only while the output skid slot is full.
// The fixed-depth pipeline runs through the exp series, Q32.32 multipliers and restoring divider.
// Reset clears all valid bits, including those of the output slots; scale_q returns to 2*pi.
`timescale 1ns / 1ps
`default_nettype none

module analog_prototype_coeff_calc_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [31:0] cfg_wr_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [3:0] cmd,
	input wire logic [31:0] norm_freq,
	input wire logic signed [22:0] gain_db,
	input wire logic [23:0] quality,
	output logic out_valid,
	input wire logic out_stall,
	output logic [47:0] coef_a,
	output logic [47:0] coef_b,
	output logic [47:0] coef_c,
	output logic [47:0] coef_d,
	output logic [47:0] coef_e,
	output logic [1:0] status
);

	localparam int LAT = apcc_pkg::LAT;
	localparam int PL = apcc_pkg::POW_LAT;
	localparam int QL = apcc_pkg::QMUL_LAT;
	localparam int DL = apcc_pkg::DIV_LAT;
	localparam int NQ = apcc_pkg::NQM;

	logic [31:0] scale_q;
	logic en;
	logic vld_s [LAT];

	apcc_pkg::ctx_t ctx_s1;
	logic signed [52:0] l2a_s1;
	apcc_pkg::ctx_t ctx_dly_s [PL];
	logic [47:0] w2_dly_s [PL-QL];
	apcc_pkg::m1_t m1_dly_s [QL];
	apcc_pkg::mid_t mid_dly_s [DL];
	apcc_pkg::fin_t fin_dly_s [QL];

	logic signed [54:0] x_a, x_i, x_s;
	logic [37:0] pa, pai, psa;
	apcc_pkg::m1_t m1_c;
	apcc_pkg::mid_t mid_c;
	logic [47:0] num1, num2;
	logic [63:0] dq1, dq2;
	apcc_pkg::res_t res_c;

	logic [63:0] qa [NQ];
	logic [39:0] qb [NQ];
	logic [63:0] pp_ll_s1 [NQ];
	logic [39:0] pp_lh_s1 [NQ];
	logic [63:0] pp_hl_s1 [NQ];
	logic [39:0] pp_hh_s1 [NQ];
	logic [63:0] qy_s2 [NQ];

	apcc_pkg::res_t out_q, skid_q;
	logic out_vld_q, skid_vld_q;
	logic take, newv;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= apcc_pkg::SCALE_RESET;
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	// pipeline advances unless the skid slot holds a beat
	assign en = !skid_vld_q;
	assign in_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// stage 1: angular frequency and log2 of the amplitude
	logic [63:0] wprod;
	assign wprod = 64'(norm_freq) * 64'(scale_q);

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1.cmd <= cmd;
			ctx_s1.qual <= quality;
			ctx_s1.w <= wprod[63:24];
			l2a_s1 <= 53'(gain_db) * 53'(apcc_pkg::DB_LOG2);
		end
	end

	// exponent inputs: A, 1/A and sqrt(A)
	assign x_s = 55'(l2a_s1);
	assign x_a = x_s <<< 1;
	assign x_i = -x_a;

	apcc_pow2 u_pow_a (.clk(clk), .en(en), .x(x_a), .y(pa));
	apcc_pow2 u_pow_i (.clk(clk), .en(en), .x(x_i), .y(pai));
	apcc_pow2 u_pow_s (.clk(clk), .en(en), .x(x_s), .y(psa));

	// side delay lines matching the exponent units, multipliers and dividers
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_dly_s[0] <= ctx_s1;
			for (int i = 1; i < PL; i++) ctx_dly_s[i] <= ctx_dly_s[i-1];
			w2_dly_s[0] <= qy_s2[0][47:0];
			for (int i = 1; i < PL - QL; i++) w2_dly_s[i] <= w2_dly_s[i-1];
			m1_dly_s[0] <= m1_c;
			for (int i = 1; i < QL; i++) m1_dly_s[i] <= m1_dly_s[i-1];
			mid_dly_s[0] <= mid_c;
			for (int i = 1; i < DL; i++) mid_dly_s[i] <= mid_dly_s[i-1];
			fin_dly_s[0] <= {mid_dly_s[DL-1], dq1, dq2};
			for (int i = 1; i < QL; i++) fin_dly_s[i] <= fin_dly_s[i-1];
		end
	end

	always_comb begin
		m1_c.ctx = ctx_dly_s[PL-1];
		m1_c.w2 = w2_dly_s[PL-QL-1];
		m1_c.a = pa;
		m1_c.ai = pai;
	end

	// Q32.32 multiplier operands: w*w, the six first-round products, two after the divider
	always_comb begin
		qa[0] = 64'(ctx_s1.w);
		qb[0] = ctx_s1.w;
		qa[1] = 64'(m1_c.ctx.w);
		qb[1] = 40'(pa);
		qa[2] = 64'(m1_c.ctx.w);
		qb[2] = 40'(pai);
		qa[3] = 64'(pa);
		qb[3] = 40'(pa);
		qa[4] = 64'(m1_c.w2);
		qb[4] = 40'(pa);
		qa[5] = 64'(m1_c.w2);
		qb[5] = 40'(pai);
		qa[6] = 64'(m1_c.ctx.w);
		qb[6] = 40'(psa);
		qa[7] = dq1;
		qb[7] = 40'(mid_dly_s[DL-1].ai);
		qa[8] = dq1;
		qb[8] = 40'(mid_dly_s[DL-1].a);
	end

	// floor(a*b / 2^32) held at all ones on overflow; partial products, then sum
	for (genvar g = 0; g < NQ; g++) begin : g_qmul
		logic [72:0] sum;
		assign sum = 73'({pp_hh_s1[g], 32'b0}) + 73'(pp_hl_s1[g]) + 73'(pp_lh_s1[g])
			+ 73'(pp_ll_s1[g][63:32]);

		always_ff @(posedge clk) begin
			if (en) begin
				pp_ll_s1[g] <= 64'(qa[g][31:0]) * 64'(qb[g][31:0]);
				pp_lh_s1[g] <= 40'(qa[g][31:0]) * 40'(qb[g][39:32]);
				pp_hl_s1[g] <= 64'(qa[g][63:32]) * 64'(qb[g][31:0]);
				pp_hh_s1[g] <= 40'(qa[g][63:32]) * 40'(qb[g][39:32]);
				qy_s2[g] <= (|sum[72:64]) ? '1 : sum[63:0];
			end
		end
	end

	// coefficients known before the divider, and divider operands
	always_comb begin
		apcc_pkg::m1_t mv;
		logic [63:0] w64, w264, a64, c0e, c1, c2, c4;
		logic so, qz;
		mv = m1_dly_s[QL-1];
		w64 = 64'(mv.ctx.w);
		w264 = 64'(mv.w2);
		a64 = 64'(mv.a);
		c0e = '0;
		c1 = '0;
		c2 = '0;
		c4 = '0;
		num1 = 48'(mv.ctx.w);
		num2 = qy_s2[1][47:0];
		unique case (mv.ctx.cmd) inside
			apcc_pkg::CMD_LP1: begin
				c0e = w64; c2 = w64;
			end
			apcc_pkg::CMD_HP1: begin
				c0e = w64; c1 = apcc_pkg::ONE_Q32;
			end
			apcc_pkg::CMD_TILT1: begin
				c0e = qy_s2[1]; c1 = a64; c2 = w64;
			end
			apcc_pkg::CMD_LS1: begin
				c0e = qy_s2[2]; c1 = apcc_pkg::ONE_Q32; c2 = qy_s2[1];
			end
			apcc_pkg::CMD_HS1: begin
				c0e = qy_s2[1]; c1 = qy_s2[3]; c2 = qy_s2[1];
			end
			apcc_pkg::CMD_LP2: begin
				c1 = w264; c4 = w264;
			end
			apcc_pkg::CMD_HP2: begin
				c1 = w264; c2 = apcc_pkg::ONE_Q32;
			end
			apcc_pkg::CMD_BP2: begin
				c1 = w264;
			end
			apcc_pkg::CMD_NOTCH2: begin
				c1 = w264; c2 = apcc_pkg::ONE_Q32; c4 = w264;
			end
			apcc_pkg::CMD_PEAK2: begin
				c1 = w264; c2 = apcc_pkg::ONE_Q32; c4 = w264;
				num1 = qy_s2[2][47:0];
			end
			apcc_pkg::CMD_TILT2: begin
				c1 = qy_s2[4]; c2 = a64; c4 = w264;
				num1 = qy_s2[6][47:0];
			end
			apcc_pkg::CMD_LS2: begin
				c1 = qy_s2[5]; c2 = apcc_pkg::ONE_Q32; c4 = qy_s2[4];
				num1 = qy_s2[6][47:0];
			end
			apcc_pkg::CMD_HS2: begin
				c1 = qy_s2[4]; c2 = qy_s2[3]; c4 = qy_s2[4];
				num1 = qy_s2[6][47:0];
			end
			default: ;
		endcase
		so = (mv.ctx.cmd >= apcc_pkg::CMD_LP2) && (mv.ctx.cmd <= apcc_pkg::CMD_HS2);
		qz = so && (mv.ctx.qual == '0);
		mid_c.cmd = mv.ctx.cmd;
		mid_c.qz = qz;
		mid_c.kill = qz || (mv.ctx.cmd > apcc_pkg::CMD_HS2);
		mid_c.o0e = apcc_pkg::to_out(c0e);
		mid_c.o1 = apcc_pkg::to_out(c1);
		mid_c.o2 = apcc_pkg::to_out(c2);
		mid_c.o4 = apcc_pkg::to_out(c4);
		mid_c.a = mv.a;
		mid_c.ai = mv.ai;
	end

	apcc_div u_div1 (.clk(clk), .en(en), .num(num1), .den(m1_dly_s[QL-1].ctx.qual), .quo(dq1));
	apcc_div u_div2 (.clk(clk), .en(en), .num(num2), .den(m1_dly_s[QL-1].ctx.qual), .quo(dq2));

	// final selection of the first and fourth coefficients, status
	always_comb begin
		apcc_pkg::fin_t fv;
		apcc_pkg::out_t o0, o3, zq;
		fv = fin_dly_s[QL-1];
		zq = '0;
		o3 = zq;
		if (fv.mid.cmd <= apcc_pkg::CMD_HS1) begin
			o0 = fv.mid.o0e;
		end else if (fv.mid.cmd == apcc_pkg::CMD_LS2) begin
			o0 = apcc_pkg::to_out(qy_s2[7]);
		end else begin
			o0 = apcc_pkg::to_out(fv.q1);
		end
		unique case (fv.mid.cmd) inside
			apcc_pkg::CMD_BP2, apcc_pkg::CMD_TILT2, apcc_pkg::CMD_LS2: o3 = apcc_pkg::to_out(fv.q1);
			apcc_pkg::CMD_PEAK2: o3 = apcc_pkg::to_out(fv.q2);
			apcc_pkg::CMD_HS2: o3 = apcc_pkg::to_out(qy_s2[8]);
			default: o3 = zq;
		endcase
		if (fv.mid.kill) begin
			res_c = '0;
			res_c.status = fv.mid.qz ? apcc_pkg::ST_QZERO : apcc_pkg::ST_OK;
		end else begin
			res_c.a = o0.val;
			res_c.b = fv.mid.o1.val;
			res_c.c = fv.mid.o2.val;
			res_c.d = o3.val;
			res_c.e = fv.mid.o4.val;
			res_c.status = (o0.sat || fv.mid.o1.sat || fv.mid.o2.sat || o3.sat || fv.mid.o4.sat)
				? apcc_pkg::ST_SAT : apcc_pkg::ST_OK;
		end
	end

	// output register with one skid slot
	assign take = out_vld_q && !out_stall;
	assign newv = en && vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) skid_vld_q <= 1'b0;
		end else if (newv) begin
			if (!out_vld_q || take) out_vld_q <= 1'b1;
			else skid_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) out_q <= skid_q;
		end else if (newv) begin
			if (!out_vld_q || take) out_q <= res_c;
			else skid_q <= res_c;
		end
	end

	assign out_valid = out_vld_q;
	assign coef_a = out_q.a;
	assign coef_b = out_q.b;
	assign coef_c = out_q.c;
	assign coef_d = out_q.d;
	assign coef_e = out_q.e;
	assign status = out_q.status;

	// a held skid beat always sits behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid slot full while output slot empty");

	// quality-zero beats carry no coefficients
	a_qzero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_q.status == apcc_pkg::ST_QZERO) |->
		(out_q.a == '0) && (out_q.b == '0) && (out_q.c == '0) && (out_q.d == '0)
		&& (out_q.e == '0))
		else $error("quality-zero result with nonzero coefficients");

	// saturation status needs a clamped coefficient
	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_q.status == apcc_pkg::ST_SAT) |->
		(out_q.a == apcc_pkg::OUT_MAX[47:0]) || (out_q.b == apcc_pkg::OUT_MAX[47:0])
		|| (out_q.c == apcc_pkg::OUT_MAX[47:0]) || (out_q.d == apcc_pkg::OUT_MAX[47:0])
		|| (out_q.e == apcc_pkg::OUT_MAX[47:0]))
		else $error("saturation flagged without a clamped coefficient");

	// coefficients are never negative and status is a defined code
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !out_q.a[47] && !out_q.b[47] && !out_q.c[47] && !out_q.d[47]
		&& !out_q.e[47] && ((out_q.status == apcc_pkg::ST_OK)
		|| (out_q.status == apcc_pkg::ST_SAT) || (out_q.status == apcc_pkg::ST_QZERO)))
		else $error("result out of range");

endmodule

`default_nettype wire
